FILE: src/rcpf_pkg.sv
// Shared types and constants for the recent coordinate pair filter.
package rcpf_pkg;

	localparam int HIST_DEPTH = 64;
	localparam int PTR_W      = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int COORD_W    = 32;
	localparam int PAIR_W     = 4 * COORD_W;
	localparam int HLEN_W     = 7;
	localparam int STATUS_W   = 2;

	localparam logic [STATUS_W-1:0] ST_NEW     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REPEAT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOSETUP = 2'd2;

	typedef logic [PAIR_W-1:0] pair_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                cfg_wr;
		logic                load;
		logic                search;
		logic                commit;
		logic                set_res;
		logic [STATUS_W-1:0] res;
		logic                out_load;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic len_zero;
		logic match;
		logic done;
	} sts_t;

endpackage

FILE: src/recent_coordinate_pair_filter.sv
// Top level: filter that reports repeats of recently seen coordinate pairs.
//
//   channel  signals                                    direction
//   in       in_valid/in_ready, cmd, first_x, first_y,  input item
//            second_x, second_y
//   out      out_valid/out_ready, status                result item
//   cfg      cfg_valid/cfg_ready, history_length        register write
//
// An item is searched against the valid history entries before its result reaches the result register;
// the search reads the pair store one entry per cycle.
// A repeat ends the search early; an unset length ends it at once.
// Reset clears the length, ring pointer and fill count; the store needs no clearing.
// A result waiting in the output register does not block the next item;
// the block stalls only when a second result is ready and the first is not taken.
module recent_coordinate_pair_filter import rcpf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [COORD_W-1:0]  first_x,
	input  logic [COORD_W-1:0]  first_y,
	input  logic [COORD_W-1:0]  second_x,
	input  logic [COORD_W-1:0]  second_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [HLEN_W-1:0]   history_length
);

	ctl_t ctl;
	sts_t sts;

	rcpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	rcpf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.history_length(history_length),
		.cmd           (cmd),
		.first_x       (first_x),
		.first_y       (first_y),
		.second_x      (second_x),
		.second_y      (second_y),
		.sts           (sts),
		.status        (status)
	);

endmodule

FILE: src/rcpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/rcpf_datapath.sv
// Datapath: item and history registers, pair store, search compare, result register.
module rcpf_datapath import rcpf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	input  logic [HLEN_W-1:0]   history_length,
	input  logic                cmd,
	input  logic [COORD_W-1:0]  first_x,
	input  logic [COORD_W-1:0]  first_y,
	input  logic [COORD_W-1:0]  second_x,
	input  logic [COORD_W-1:0]  second_y,
	output sts_t                sts,
	output logic [STATUS_W-1:0] status
);

	logic [HLEN_W-1:0]   hlen_q;
	logic [PTR_W-1:0]    wp_q;
	logic [CNT_W-1:0]    vc_q;
	logic [CNT_W-1:0]    idx_q;
	logic                rd_vld_q;
	pair_t               key_q;
	logic [STATUS_W-1:0] res_q;
	logic [STATUS_W-1:0] status_q;

	logic [CNT_W-1:0]    len;
	logic [CNT_W-1:0]    wp_inc;
	logic                issue;
	pair_t               rdata;

	// Lengths above the store depth act as the full depth.
	assign len = (CNT_W'(hlen_q) > CNT_W'(HIST_DEPTH)) ? CNT_W'(HIST_DEPTH)
	                                                    : CNT_W'(hlen_q);
	assign wp_inc = CNT_W'(wp_q) + CNT_W'(1);
	assign issue  = ctl.search && (idx_q < vc_q);

	rcpf_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(HIST_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ctl.commit),
		.waddr(wp_q),
		.wdata(key_q),
		.raddr(idx_q[PTR_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlen_q   <= '0;
			wp_q     <= '0;
			vc_q     <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.cfg_wr) begin
				hlen_q <= history_length;
				wp_q   <= '0;
				vc_q   <= '0;
			end
			if (ctl.load) begin
				idx_q    <= '0;
				rd_vld_q <= 1'b0;
				if (cmd) begin
					wp_q <= '0;
					vc_q <= '0;
				end
			end else if (ctl.search) begin
				rd_vld_q <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (ctl.commit) begin
				// Advance the ring pointer, wrapping at the active length.
				wp_q <= (wp_inc >= len) ? '0 : wp_inc[PTR_W-1:0];
				if (vc_q < len) begin
					vc_q <= vc_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q <= {second_y, second_x, first_y, first_x};
		end
		if (ctl.set_res) begin
			res_q <= ctl.res;
		end
		if (ctl.out_load) begin
			status_q <= res_q;
		end
	end

	assign sts.len_zero = (len == '0);
	assign sts.match    = rd_vld_q && (rdata == key_q);
	assign sts.done     = !rd_vld_q && (idx_q == vc_q);
	assign status       = status_q;

endmodule

FILE: src/rcpf_ctrl.sv
// Controller: sequences accept, search, record and result handoff.
module rcpf_ctrl import rcpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic cfg_valid,
	output logic cfg_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl          = '0;
		ctl.res      = ST_NEW;
		state_d      = state_q;
		ctl.cfg_wr   = cfg_valid && cfg_ready;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					ctl.load = 1'b1;
					state_d  = S_SEARCH;
				end
			end
			S_SEARCH: begin
				ctl.search = 1'b1;
				if (sts.len_zero) begin
					ctl.set_res = 1'b1;
					ctl.res     = ST_NOSETUP;
					state_d     = S_FINISH;
				end else if (sts.match) begin
					ctl.set_res = 1'b1;
					ctl.res     = ST_REPEAT;
					state_d     = S_FINISH;
				end else if (sts.done) begin
					ctl.set_res = 1'b1;
					ctl.res     = ST_NEW;
					ctl.commit  = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_FINISH: begin
				// Hold until the output register is free.
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
